>>> rtl/cbb_pkg.sv
`timescale 1ns / 1ps

package cbb_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int ID_W      = 27;
	localparam int STATUS_W  = 2;
	localparam int LEN_W     = 11;
	localparam int CFG_IDX_W = 3;

	// Card id decode widths
	localparam int TYPE_W   = 4;   // top digit, 0..13 for a 27-bit id
	localparam int REM_W    = 24;  // id below the top digit, < 10^7
	localparam int SERIAL_W = 20;  // low six digits, < 10^6
	localparam int BIT_W    = 3;
	localparam int BYTE_W   = SERIAL_W - BIT_W;

	localparam int NUM_TYPES     = 7;
	localparam int TYPE_DIV      = 10000000;
	localparam int SERIAL_DIV    = 1000000;
	localparam int MAX_TYPE_DIG  = ((1 << ID_W) - 1) / TYPE_DIV;
	localparam int MAX_STAT_DIG  = 9;

	localparam int REGION_BYTES_DEF = 1024;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNMARK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_LOST  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic load_s1;   // capture the accepted transaction
		logic load_s2;   // station digit stripped
		logic load_s3;   // range check, address, byte read
		logic clr_step;  // zero one byte of the sweep
		logic commit;    // write back and load the result
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic item_clear;  // latched command is clear-all
		logic clr_last;    // sweep at the last byte
	} dp_status_t;

endpackage

>>> rtl/cbb_in_if.sv
`timescale 1ns / 1ps

interface cbb_in_if;
	logic                       valid;
	logic                       ready;
	logic [cbb_pkg::CMD_W-1:0]  cmd;
	logic [cbb_pkg::ID_W-1:0]   card_id;

	modport source (output valid, output cmd, output card_id, input ready);
	modport sink (input valid, input cmd, input card_id, output ready);
endinterface

>>> rtl/cbb_out_if.sv
`timescale 1ns / 1ps

interface cbb_out_if;
	logic                          valid;
	logic                          ready;
	logic [cbb_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

>>> rtl/card_blacklist_bitmap_top.sv
`timescale 1ns / 1ps

// Lost-card bitmap with seven regions of REGION_BYTES bytes, one per card type.
// Each req transaction carries a command and an eight-digit card id; each one
// gives exactly one rsp transaction with its status. Query, mark and unmark pass
// through S_IDLE and S_DEC (split the id into type and serial), S_READ (range
// check and byte read) and S_MOD (write the byte back, load the result register;
// waits until the previous result is taken). Clear-all and reset both run a sweep
// over all 7 * REGION_BYTES bytes of the store that zeroes one byte per cycle
// while req is held not ready; clear-all then answers with an ok status. A result
// may wait in its register while the next transaction is accepted and decoded.
// Length registers are written on cfg_we, index 0 to 6 for card types 1 to 7;
// other indexes are ignored.

module card_blacklist_bitmap_top #(
	parameter int REGION_BYTES = cbb_pkg::REGION_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cbb_in_if.sink                         req,
	cbb_out_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [cbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbb_pkg::LEN_W-1:0]      cfg_data
);

	cbb_pkg::ctrl_cmd_t  cmd;
	cbb_pkg::dp_status_t st;

	// Sequencer
	cbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Decode, bitmap store and result register
	cbb_dpath #(
		.REGION_BYTES (REGION_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_cmd     (req.cmd),
		.in_card_id (req.card_id),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.st         (st),
		.status     (rsp.status)
	);

endmodule

>>> rtl/cbb_dpath.sv
`timescale 1ns / 1ps

module cbb_dpath #(
	parameter int REGION_BYTES = cbb_pkg::REGION_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [cbb_pkg::CMD_W-1:0]         in_cmd,
	input  logic [cbb_pkg::ID_W-1:0]          in_card_id,
	input  logic                              cfg_we,
	input  logic [cbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbb_pkg::LEN_W-1:0]         cfg_data,
	input  cbb_pkg::ctrl_cmd_t                cmd,
	output cbb_pkg::dp_status_t               st,
	output logic [cbb_pkg::STATUS_W-1:0]      status
);

	localparam int DEPTH  = cbb_pkg::NUM_TYPES * REGION_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [cbb_pkg::LEN_W-1:0]    len_q [cbb_pkg::NUM_TYPES];
	logic [7:0]                   mem [DEPTH];

	logic [cbb_pkg::CMD_W-1:0]    cmd_q;
	logic [cbb_pkg::TYPE_W-1:0]   type_s1, type_s2;
	logic [cbb_pkg::REM_W-1:0]    rem_s1;
	logic [cbb_pkg::SERIAL_W-1:0] serial_s2;
	logic [ADDR_W-1:0]            addr_s3;
	logic [cbb_pkg::BIT_W-1:0]    bit_s3;
	logic                         oor_s3;
	logic [7:0]                   rdata_q;
	logic [ADDR_W-1:0]            clr_addr_q;
	logic [cbb_pkg::STATUS_W-1:0] status_q;

	logic [cbb_pkg::TYPE_W-1:0]   type_d;
	logic [cbb_pkg::REM_W-1:0]    rem_d;
	logic [cbb_pkg::SERIAL_W-1:0] serial_d;
	logic [cbb_pkg::BYTE_W-1:0]   byte_ix;
	logic [cbb_pkg::LEN_W-1:0]    len_sel;
	logic                         type_ok;
	logic                         oor_d;
	logic [ADDR_W-1:0]            addr_d;
	logic [7:0]                   mask;
	logic                         upd;
	logic                         we;
	logic [ADDR_W-1:0]            waddr;
	logic [7:0]                   wdata;
	logic [cbb_pkg::STATUS_W-1:0] status_d;

	// Length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cbb_pkg::NUM_TYPES; k++) begin
				len_q[k] <= cbb_pkg::LEN_RESET;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < cbb_pkg::NUM_TYPES; k++) begin
				if (cfg_index == cbb_pkg::CFG_IDX_W'(k)) begin
					len_q[k] <= cfg_data;
				end
			end
		end
	end

	// Top digit: compare against each multiple of 10^7
	always_comb begin
		type_d = '0;
		rem_d  = cbb_pkg::REM_W'(in_card_id);
		for (int k = 1; k <= cbb_pkg::MAX_TYPE_DIG; k++) begin
			if (in_card_id >= cbb_pkg::ID_W'(k * cbb_pkg::TYPE_DIV)) begin
				type_d = cbb_pkg::TYPE_W'(k);
				rem_d  = cbb_pkg::REM_W'(in_card_id - cbb_pkg::ID_W'(k * cbb_pkg::TYPE_DIV));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			cmd_q   <= in_cmd;
			type_s1 <= type_d;
			rem_s1  <= rem_d;
		end
	end

	// Station digit dropped, six-digit serial left
	always_comb begin
		serial_d = cbb_pkg::SERIAL_W'(rem_s1);
		for (int k = 1; k <= cbb_pkg::MAX_STAT_DIG; k++) begin
			if (rem_s1 >= cbb_pkg::REM_W'(k * cbb_pkg::SERIAL_DIV)) begin
				serial_d = cbb_pkg::SERIAL_W'(rem_s1 - cbb_pkg::REM_W'(k * cbb_pkg::SERIAL_DIV));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s2) begin
			type_s2   <= type_s1;
			serial_s2 <= serial_d;
		end
	end

	// Range check and region address
	assign byte_ix = serial_s2[cbb_pkg::SERIAL_W-1:cbb_pkg::BIT_W];
	assign type_ok = (type_s2 >= cbb_pkg::TYPE_W'(1))
		&& (type_s2 <= cbb_pkg::TYPE_W'(cbb_pkg::NUM_TYPES));

	always_comb begin
		len_sel = '0;
		for (int k = 0; k < cbb_pkg::NUM_TYPES; k++) begin
			if (type_s2 == cbb_pkg::TYPE_W'(k + 1)) begin
				len_sel = len_q[k];
			end
		end
	end

	assign oor_d = !type_ok
		|| (byte_ix >= cbb_pkg::BYTE_W'(len_sel))
		|| (byte_ix >= cbb_pkg::BYTE_W'(REGION_BYTES));
	assign addr_d = ADDR_W'(type_s2 - cbb_pkg::TYPE_W'(1)) * ADDR_W'(REGION_BYTES)
		+ ADDR_W'(byte_ix);

	always_ff @(posedge clk) begin
		if (cmd.load_s3) begin
			addr_s3 <= addr_d;
			bit_s3  <= serial_s2[cbb_pkg::BIT_W-1:0];
			oor_s3  <= oor_d;
		end
	end

	// Clear sweep counter
	assign st.clr_last   = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign st.item_clear = (cmd_q == cbb_pkg::CMD_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			if (st.clr_last) begin
				clr_addr_q <= '0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	// Write-back byte
	assign mask  = 8'(1) << bit_s3;
	assign upd   = cmd.commit && !oor_s3
		&& ((cmd_q == cbb_pkg::CMD_MARK) || (cmd_q == cbb_pkg::CMD_UNMARK));
	assign we    = cmd.clr_step || upd;
	assign waddr = cmd.clr_step ? clr_addr_q : addr_s3;

	always_comb begin
		if (cmd.clr_step) begin
			wdata = '0;
		end else if (cmd_q == cbb_pkg::CMD_MARK) begin
			wdata = rdata_q | mask;
		end else begin
			wdata = rdata_q & ~mask;
		end
	end

	// Bitmap store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.load_s3 && !oor_d) begin
			rdata_q <= mem[addr_d];
		end
	end

	// Result
	always_comb begin
		if (cmd_q == cbb_pkg::CMD_CLEAR) begin
			status_d = cbb_pkg::STAT_OK;
		end else if (oor_s3) begin
			status_d = cbb_pkg::STAT_RANGE;
		end else if ((cmd_q == cbb_pkg::CMD_QUERY) && ((rdata_q & mask) != 8'd0)) begin
			status_d = cbb_pkg::STAT_LOST;
		end else begin
			status_d = cbb_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
		end
	end

	assign status = status_q;

endmodule

>>> rtl/cbb_ctrl.sv
`timescale 1ns / 1ps

module cbb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  cbb_pkg::dp_status_t  st,
	output cbb_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DEC,
		S_READ,
		S_MOD
	} state_t;

	state_t state_q;
	logic   item_q;      // sweep belongs to a clear-all transaction
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	// Commands
	assign req_ready    = (state_q == S_IDLE);
	assign cmd.load_s1  = (state_q == S_IDLE) && req_valid;
	assign cmd.load_s2  = (state_q == S_DEC);
	assign cmd.load_s3  = (state_q == S_READ);
	assign cmd.clr_step = (state_q == S_CLEAR);
	assign cmd.commit   = (state_q == S_MOD) && slot_free;
	assign rsp_valid    = rsp_valid_q;

	// State and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			item_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (st.clr_last) begin
						state_q <= item_q ? S_MOD : S_IDLE;
						item_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (st.item_clear) begin
						state_q <= S_CLEAR;
						item_q  <= 1'b1;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
